[design/sbqeq_pkg.sv]
// Shared types and constants for the stereo biquad cascade equalizer.
// No dependencies; used by every module in this folder.
package sbqeq_pkg;

  localparam int NUM_BANDS_DEF = 7;
  localparam int NCOEF         = 5;
  localparam logic [16:0] GLIDE_RESET = 17'd65372;
  localparam logic [16:0] GLIDE_ONE   = 17'd65536;
  localparam logic [2:0]  PH_LAST     = 3'd5;

  localparam logic [1:0] OP_STEREO   = 2'd0;
  localparam logic [1:0] OP_MONO     = 2'd1;
  localparam logic [1:0] OP_WR_TGT   = 2'd2;
  localparam logic [1:0] OP_WR_BOTH  = 2'd3;

  localparam logic [2:0] C_B0 = 3'd0;
  localparam logic [2:0] C_B1 = 3'd1;
  localparam logic [2:0] C_B2 = 3'd2;
  localparam logic [2:0] C_A1 = 3'd3;
  localparam logic [2:0] C_A2 = 3'd4;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [23:0] left_in;
    logic signed [23:0] right_in;
    logic [2:0]         band;
    logic [2:0]         coef_select;
    logic signed [31:0] coef_value;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] left_out;
    logic signed [23:0] right_out;
    logic               clipped;
  } out_item_t;

  typedef logic [NCOEF-1:0][31:0] coef_row_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_GLIDE,
    S_FILT,
    S_DONE
  } eq_state_t;

  typedef struct packed {
    logic       load;
    logic       glide;
    logic       filt;
    logic [2:0] ph;
  } seq_ctl_t;

  function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
    if (v > 50'sh0_7FFF_FFFF_FFFF) begin
      return 48'sh7FFF_FFFF_FFFF;
    end else if (v < -50'sh0_8000_0000_0000) begin
      return 48'sh8000_0000_0000;
    end
    return v[47:0];
  endfunction

endpackage

[design/sbqeq_coef.sv]
// Live and target coefficient rows, one row per band, and the glide unit.
// Depends on sbqeq_pkg.
module sbqeq_coef #(
  parameter int NUM_BANDS = sbqeq_pkg::NUM_BANDS_DEF,
  parameter int BW = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic                 wr_live,
  input  logic [2:0]           wr_band,
  input  logic [2:0]           wr_sel,
  input  logic signed [31:0]   wr_val,
  input  sbqeq_pkg::seq_ctl_t  ctl,
  input  logic [BW-1:0]        band,
  input  logic [16:0]          glide_k,
  output sbqeq_pkg::coef_row_t live_row
);

  sbqeq_pkg::coef_row_t live_r [NUM_BANDS];
  sbqeq_pkg::coef_row_t tgt_r  [NUM_BANDS];
  logic signed [50:0] p_r;
  logic signed [50:0] p_nxt;
  logic signed [32:0] d;
  logic signed [17:0] step;
  logic [16:0]        g;
  logic [2:0]         prev_ph;
  logic [2:0]         csel;
  logic signed [34:0] inc;
  logic               wr_ok;
  logic [BW-1:0]      wb;

  assign live_row = live_r[band];
  assign g     = (glide_k > sbqeq_pkg::GLIDE_ONE) ? sbqeq_pkg::GLIDE_ONE : glide_k;
  assign step  = $signed({1'b0, sbqeq_pkg::GLIDE_ONE - g});
  assign csel  = (ctl.ph == sbqeq_pkg::PH_LAST) ? sbqeq_pkg::C_B0 : ctl.ph;
  assign d     = $signed({tgt_r[band][csel][31], tgt_r[band][csel]})
               - $signed({live_r[band][csel][31], live_r[band][csel]});
  assign p_nxt = d * step;
  assign prev_ph = ctl.ph - 3'd1;
  assign inc   = p_r[50:16];
  assign wr_ok = ({2'b0, wr_band} < 5'(NUM_BANDS)) && (wr_sel <= sbqeq_pkg::C_A2);
  assign wb    = BW'(wr_band);

  always_ff @(posedge clk) begin
    if (ctl.glide && ctl.ph != sbqeq_pkg::PH_LAST) begin
      p_r <= p_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BANDS; i++) begin
        live_r[i] <= '0;
        tgt_r[i]  <= '0;
      end
    end else begin
      if (wr_en && wr_ok) begin
        tgt_r[wb][wr_sel] <= wr_val;
        if (wr_live) begin
          live_r[wb][wr_sel] <= wr_val;
        end
      end
      if (ctl.glide && ctl.ph != 3'd0) begin
        live_r[band][prev_ph] <= live_r[band][prev_ph] + inc[31:0];
      end
    end
  end

endmodule

[design/sbqeq_lane.sv]
// One biquad lane: multiplier, accumulator and delay rows for all bands.
// Depends on sbqeq_pkg; coefficients come from sbqeq_coef.
module sbqeq_lane #(
  parameter int NUM_BANDS = sbqeq_pkg::NUM_BANDS_DEF,
  parameter int BW = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  sbqeq_pkg::seq_ctl_t  ctl,
  input  logic [BW-1:0]        band,
  input  logic signed [23:0]   x_in,
  input  sbqeq_pkg::coef_row_t coefs,
  output logic signed [23:0]   y_out,
  output logic                 clip_out
);

  logic signed [47:0] z0_r [NUM_BANDS];
  logic signed [47:0] z1_r [NUM_BANDS];
  logic signed [23:0] x_r;
  logic signed [23:0] y_r;
  logic               clip_r;
  logic signed [55:0] p_r;
  logic signed [49:0] t_r;
  logic signed [23:0] opnd;
  logic signed [31:0] c;
  logic signed [49:0] sh;
  logic signed [49:0] acc;
  logic signed [49:0] yr;
  logic signed [49:0] t0;

  assign y_out    = y_r;
  assign clip_out = clip_r;
  assign opnd = (ctl.ph == 3'd2 || ctl.ph == 3'd4) ? y_r : x_r;
  assign sh   = 50'(p_r >>> 10);
  assign acc  = sh + 50'(z0_r[band]);
  assign yr   = (acc + 50'sd65536) >>> 17;
  assign t0   = t_r - sh + 50'(z1_r[band]);

  always_comb begin
    unique case (ctl.ph)
      3'd0:    c = $signed(coefs[sbqeq_pkg::C_B0]);
      3'd1:    c = $signed(coefs[sbqeq_pkg::C_B1]);
      3'd2:    c = $signed(coefs[sbqeq_pkg::C_A1]);
      3'd3:    c = $signed(coefs[sbqeq_pkg::C_B2]);
      default: c = $signed(coefs[sbqeq_pkg::C_A2]);
    endcase
  end

  always_ff @(posedge clk) begin
    if (en && ctl.filt) begin
      p_r <= opnd * c;
      if (ctl.ph == 3'd2 || ctl.ph == 3'd4) begin
        t_r <= sh;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BANDS; i++) begin
        z0_r[i] <= '0;
        z1_r[i] <= '0;
      end
      x_r    <= '0;
      y_r    <= '0;
      clip_r <= 1'b0;
    end else if (en) begin
      if (ctl.load) begin
        x_r    <= x_in;
        clip_r <= 1'b0;
      end
      if (ctl.filt) begin
        unique case (ctl.ph)
          3'd1: begin
            if (yr > 50'sd8388607) begin
              y_r    <= 24'sh7FFFFF;
              clip_r <= 1'b1;
            end else if (yr < -50'sd8388608) begin
              y_r    <= 24'sh800000;
              clip_r <= 1'b1;
            end else begin
              y_r <= yr[23:0];
            end
          end
          3'd3:    z0_r[band] <= sbqeq_pkg::sat48(t0);
          3'd5: begin
            z1_r[band] <= sbqeq_pkg::sat48(t_r - sh);
            x_r        <= y_r;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

[design/stereo_biquad_cascade_eq.sv]
// Top level of the stereo biquad cascade equalizer: sequencer, two lanes, merge.
// Depends on sbqeq_pkg, sbqeq_coef and sbqeq_lane.
//
//  channel | ports                          | dir | payload
//  in      | in_valid in_ready in_data      | in  | sbqeq_pkg::in_item_t
//  out     | out_valid out_ready out_data   | out | sbqeq_pkg::out_item_t
//  cfg     | cfg_valid cfg_ready cfg_data   | in  | glide factor, 17 bits
//
// Per band, a sample item runs a glide pass through one shared multiplier and then
// a filter pass through each lane's single multiplier.
// Reset clears coefficients and delays and restores the default glide factor.
// A result waiting on out_ready does not block the next input transfer.
module stereo_biquad_cascade_eq #(
  parameter int NUM_BANDS = sbqeq_pkg::NUM_BANDS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sbqeq_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sbqeq_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [16:0]          cfg_data
);

  localparam int BW = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
  localparam logic [BW-1:0] BAND_LAST = BW'(NUM_BANDS - 1);

  sbqeq_pkg::eq_state_t state_r, state_nxt;
  logic [BW-1:0]        band_r, band_nxt;
  logic [2:0]           ph_r, ph_nxt;
  logic                 stereo_r;
  logic [16:0]          glide_r;
  logic                 out_valid_r;
  sbqeq_pkg::out_item_t out_r;
  sbqeq_pkg::seq_ctl_t  ctl;
  sbqeq_pkg::coef_row_t live_row;
  logic                 in_xfer;
  logic                 is_sample;
  logic                 emit;
  logic signed [23:0]   y_l, y_r_lane;
  logic                 clip_l, clip_rl;

  assign in_ready  = (state_r == sbqeq_pkg::S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign is_sample = (in_data.operation == sbqeq_pkg::OP_STEREO)
                  || (in_data.operation == sbqeq_pkg::OP_MONO);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt = state_r;
    band_nxt  = band_r;
    ph_nxt    = ph_r;
    emit      = 1'b0;
    ctl       = '0;
    ctl.ph    = ph_r;
    unique case (state_r)
      sbqeq_pkg::S_IDLE: begin
        if (in_xfer && is_sample) begin
          ctl.load  = 1'b1;
          state_nxt = sbqeq_pkg::S_GLIDE;
          band_nxt  = '0;
          ph_nxt    = '0;
        end
      end
      sbqeq_pkg::S_GLIDE: begin
        ctl.glide = 1'b1;
        if (ph_r == sbqeq_pkg::PH_LAST) begin
          ph_nxt    = '0;
          state_nxt = sbqeq_pkg::S_FILT;
        end else begin
          ph_nxt = ph_r + 3'd1;
        end
      end
      sbqeq_pkg::S_FILT: begin
        ctl.filt = 1'b1;
        if (ph_r == sbqeq_pkg::PH_LAST) begin
          ph_nxt = '0;
          if (band_r == BAND_LAST) begin
            state_nxt = sbqeq_pkg::S_DONE;
          end else begin
            band_nxt  = band_r + BW'(1);
            state_nxt = sbqeq_pkg::S_GLIDE;
          end
        end else begin
          ph_nxt = ph_r + 3'd1;
        end
      end
      default: begin
        if (!out_valid_r || out_ready) begin
          emit      = 1'b1;
          state_nxt = sbqeq_pkg::S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sbqeq_pkg::S_IDLE;
      band_r      <= '0;
      ph_r        <= '0;
      stereo_r    <= 1'b0;
      glide_r     <= sbqeq_pkg::GLIDE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      band_r  <= band_nxt;
      ph_r    <= ph_nxt;
      if (cfg_valid && cfg_ready) begin
        glide_r <= cfg_data;
      end
      if (ctl.load) begin
        stereo_r <= (in_data.operation == sbqeq_pkg::OP_STEREO);
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r.left_out  <= y_l;
      out_r.right_out <= stereo_r ? y_r_lane : 24'sd0;
      out_r.clipped   <= clip_l || (stereo_r && clip_rl);
    end
  end

  sbqeq_coef #(.NUM_BANDS(NUM_BANDS), .BW(BW)) u_coef (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (in_xfer && !is_sample),
    .wr_live  (in_data.operation == sbqeq_pkg::OP_WR_BOTH),
    .wr_band  (in_data.band),
    .wr_sel   (in_data.coef_select),
    .wr_val   (in_data.coef_value),
    .ctl      (ctl),
    .band     (band_r),
    .glide_k  (glide_r),
    .live_row (live_row)
  );

  sbqeq_lane #(.NUM_BANDS(NUM_BANDS), .BW(BW)) u_lane_l (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (1'b1),
    .ctl      (ctl),
    .band     (band_r),
    .x_in     (in_data.left_in),
    .coefs    (live_row),
    .y_out    (y_l),
    .clip_out (clip_l)
  );

  sbqeq_lane #(.NUM_BANDS(NUM_BANDS), .BW(BW)) u_lane_r (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (ctl.load ? (in_data.operation == sbqeq_pkg::OP_STEREO) : stereo_r),
    .ctl      (ctl),
    .band     (band_r),
    .x_in     (in_data.right_in),
    .coefs    (live_row),
    .y_out    (y_r_lane),
    .clip_out (clip_rl)
  );

  a_band_range: assert property (@(posedge clk) disable iff (!rst_n)
    band_r <= BAND_LAST) else $error("band counter out of range");

  a_ph_range: assert property (@(posedge clk) disable iff (!rst_n)
    ph_r <= sbqeq_pkg::PH_LAST) else $error("phase counter out of range");

  a_sample_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_data.operation == sbqeq_pkg::OP_STEREO ||
     in_data.operation == sbqeq_pkg::OP_MONO)) |=> (state_r == sbqeq_pkg::S_GLIDE))
    else $error("sample transfer did not start glide");

  a_emit_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == sbqeq_pkg::S_DONE))
    else $error("result raised outside done state");

endmodule
